>>> rtl/assert_macros.svh
// Assertion macros shared by the invoice record parser modules.
// Depends on nothing; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// A property that must hold at every clock edge outside reset.
`define IRP_ASSERT(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
// A condition that must be followed by another in the same cycle.
`define IRP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// A condition that must be followed by another in the next cycle.
`define IRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define IRP_ASSERT(label, clk, rst_n, expr)
`define IRP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define IRP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/irp_pkg.sv
// Types, codes and defaults of the invoice record parser.
// Used by every module of the block; depends on nothing.
package irp_pkg;

    // Default field sizes, the hard cap on the address length and the queue depth.
    localparam int ID_BYTES_DEF    = 20;
    localparam int NONCE_BYTES_DEF = 16;
    localparam int SIG_BYTES_DEF   = 64;
    localparam int ADDR_CAP_DEF    = 1023;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Configuration port.
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 10;
    localparam logic [CFG_INDEX_W-1:0] CFG_ADDRESS_LIMIT = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MEMO_LIMIT    = 4'd1;
    localparam logic [9:0] ADDRESS_LIMIT_RESET = 10'd128;
    localparam logic [7:0] MEMO_LIMIT_RESET    = 8'd255;

    // Field codes of payload results.
    localparam logic [2:0] FC_ADDRESS  = 3'd0;
    localparam logic [2:0] FC_MERCHANT = 3'd1;
    localparam logic [2:0] FC_NONCE    = 3'd2;
    localparam logic [2:0] FC_MEMO     = 3'd3;
    localparam logic [2:0] FC_SIG      = 3'd4;

    // Status codes; ST_OK also means no error recorded.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TRUNCATED = 2'd1;
    localparam logic [1:0] ST_ADDR_LONG = 2'd2;
    localparam logic [1:0] ST_MEMO_LONG = 2'd3;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } item_t;

    typedef struct packed {
        logic        kind;
        logic [2:0]  field_code;
        logic [9:0]  byte_offset;
        logic [7:0]  byte_value;
        logic [1:0]  status;
        logic [7:0]  version_out;
        logic [7:0]  network_out;
        logic [63:0] amount_out;
        logic [31:0] time_out;
        logic [15:0] expiry_out;
        logic [15:0] address_length;
        logic [7:0]  memo_length;
    } result_t;

    // One queue entry: the payload and/or status results caused by one byte.
    typedef struct packed {
        logic        has_payload;
        logic        has_status;
        logic [2:0]  field_code;
        logic [9:0]  byte_offset;
        logic [7:0]  byte_value;
        logic [1:0]  status;
        logic [7:0]  version;
        logic [7:0]  network;
        logic [63:0] amount;
        logic [31:0] timestamp;
        logic [15:0] expiry;
        logic [15:0] addr_size;
        logic [7:0]  memo_size;
    } entry_t;

    typedef struct packed {
        logic                   valid;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_write_t;

endpackage

>>> rtl/invoice_record_parser_unit.sv
// Top level of the invoice record parser: front end, entry queue and back end.
// Depends on irp_pkg, irp_front, irp_queue and irp_back.
//
//   channel   direction   handshake               payload
//   in        in          in_valid / in_ready     in_data   (irp_pkg::item_t)
//   out       out         out_valid / out_ready   out_data  (irp_pkg::result_t)
//   cfg       in          cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One byte is taken per cycle while the queue has room; the front end does the
// whole field step for it in that cycle. A byte that yields a payload and a status
// result puts both on the result channel, so the sustained rate is set by the back
// end's single output register: one result per cycle while out_ready is high.
// in_ready drops only while the entry queue is full. Reset clears the parse state
// and restores the limits to 128 and 255; no clearing pass. cfg_ready is always high.
module invoice_record_parser_unit #(
    parameter int ID_BYTES    = irp_pkg::ID_BYTES_DEF,
    parameter int NONCE_BYTES = irp_pkg::NONCE_BYTES_DEF,
    parameter int SIG_BYTES   = irp_pkg::SIG_BYTES_DEF,
    parameter int ADDR_CAP    = irp_pkg::ADDR_CAP_DEF,
    parameter int QUEUE_DEPTH = irp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  irp_pkg::item_t                    in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output irp_pkg::result_t                  out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [irp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [irp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    irp_pkg::cfg_write_t cfg_write;
    logic                push_valid, push_ready;
    irp_pkg::entry_t     push_data;
    logic                pop_valid, pop_ready;
    irp_pkg::entry_t     pop_data;

    assign cfg_ready       = 1'b1;
    assign cfg_write.valid = cfg_valid && cfg_ready;
    assign cfg_write.index = cfg_index;
    assign cfg_write.data  = cfg_data;

    irp_front #(
        .ID_BYTES    (ID_BYTES),
        .NONCE_BYTES (NONCE_BYTES),
        .SIG_BYTES   (SIG_BYTES),
        .ADDR_CAP    (ADDR_CAP)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    irp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    irp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

>>> rtl/irp_front.sv
// Front end of the invoice record parser: walks the record fields byte by byte,
// holds the limits and the assembled numbers, and builds queue entries. Uses irp_pkg.
`include "assert_macros.svh"
module irp_front #(
    parameter int ID_BYTES    = irp_pkg::ID_BYTES_DEF,
    parameter int NONCE_BYTES = irp_pkg::NONCE_BYTES_DEF,
    parameter int SIG_BYTES   = irp_pkg::SIG_BYTES_DEF,
    parameter int ADDR_CAP    = irp_pkg::ADDR_CAP_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  irp_pkg::cfg_write_t cfg_write,
    input  logic                in_valid,
    output logic                in_ready,
    input  irp_pkg::item_t      in_data,
    output logic                push_valid,
    input  logic                push_ready,
    output irp_pkg::entry_t     push_data
);

    localparam int MAX_A     = (ADDR_CAP > 255) ? ADDR_CAP : 255;
    localparam int MAX_B     = (ID_BYTES > NONCE_BYTES) ? ID_BYTES : NONCE_BYTES;
    localparam int MAX_C     = (MAX_B > SIG_BYTES) ? MAX_B : SIG_BYTES;
    localparam int MAX_FIELD = (MAX_A > MAX_C) ? MAX_A : MAX_C;
    localparam int CNT_W     = $clog2(MAX_FIELD + 1);

    typedef enum logic [3:0] {
        PH_VER, PH_NET, PH_AMT, PH_ALEN, PH_ADDR, PH_ID, PH_NONCE,
        PH_TIME, PH_EXP, PH_MLEN, PH_MEMO, PH_SIG, PH_DONE, PH_ERR
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   field_count_reg, field_count_next;
    logic [15:0]        addr_size_reg, addr_size_next;
    logic [7:0]         memo_size_reg, memo_size_next;
    logic [7:0]         version_reg, version_next;
    logic [7:0]         network_reg, network_next;
    logic [63:0]        amount_reg, amount_next;
    logic [31:0]        time_reg, time_next;
    logic [15:0]        expiry_reg, expiry_next;
    logic [1:0]         error_reg, error_next;
    logic [9:0]         address_limit_reg;
    logic [7:0]         memo_limit_reg;

    logic               accept;
    logic [7:0]         b;
    logic [CNT_W-1:0]   cnt_inc;
    logic [16:0]        cnt_ext;
    logic [15:0]        limit_eff;
    logic [15:0]        limit_ext;
    logic [15:0]        cap_ext;
    irp_pkg::entry_t    entry;

    assign in_ready  = push_ready;
    assign accept    = in_valid && in_ready;
    assign b         = in_data.data_byte;
    assign cnt_inc   = field_count_reg + 1'b1;
    assign cnt_ext   = 17'(cnt_inc);
    assign limit_ext = 16'(address_limit_reg);
    assign cap_ext   = 16'(ADDR_CAP);
    assign limit_eff = (limit_ext < cap_ext) ? limit_ext : cap_ext;

    always_comb
    begin
        phase_next       = phase_reg;
        field_count_next = field_count_reg;
        addr_size_next   = addr_size_reg;
        memo_size_next   = memo_size_reg;
        version_next     = version_reg;
        network_next     = network_reg;
        amount_next      = amount_reg;
        time_next        = time_reg;
        expiry_next      = expiry_reg;
        error_next       = error_reg;
        entry            = '0;

        if (accept)
        begin
            unique case (phase_reg)
                PH_VER:
                begin
                    version_next = b;
                    phase_next   = PH_NET;
                end
                PH_NET:
                begin
                    network_next = b;
                    phase_next   = PH_AMT;
                end
                PH_AMT:
                begin
                    amount_next = amount_reg | (64'(b) << {field_count_reg[2:0], 3'b000});
                    field_count_next = cnt_inc;
                    if (field_count_reg[2:0] == 3'd7)
                    begin
                        phase_next       = PH_ALEN;
                        field_count_next = '0;
                    end
                end
                PH_ALEN:
                begin
                    addr_size_next = addr_size_reg | (16'(b) << {field_count_reg[0], 3'b000});
                    field_count_next = cnt_inc;
                    if (field_count_reg[0])
                    begin
                        field_count_next = '0;
                        if (addr_size_next > limit_eff)
                        begin
                            error_next = irp_pkg::ST_ADDR_LONG;
                            phase_next = PH_ERR;
                        end
                        else if (addr_size_next == 16'd0)
                            phase_next = PH_ID;
                        else
                            phase_next = PH_ADDR;
                    end
                end
                PH_TIME:
                begin
                    time_next = time_reg | (32'(b) << {field_count_reg[1:0], 3'b000});
                    field_count_next = cnt_inc;
                    if (field_count_reg[1:0] == 2'd3)
                    begin
                        phase_next       = PH_EXP;
                        field_count_next = '0;
                    end
                end
                PH_EXP:
                begin
                    expiry_next = expiry_reg | (16'(b) << {field_count_reg[0], 3'b000});
                    field_count_next = cnt_inc;
                    if (field_count_reg[0])
                    begin
                        phase_next       = PH_MLEN;
                        field_count_next = '0;
                    end
                end
                PH_MLEN:
                begin
                    memo_size_next = b;
                    if (b > memo_limit_reg)
                    begin
                        error_next = irp_pkg::ST_MEMO_LONG;
                        phase_next = PH_ERR;
                    end
                    else if (b == 8'd0)
                        phase_next = PH_SIG;
                    else
                        phase_next = PH_MEMO;
                end
                PH_ADDR, PH_ID, PH_NONCE, PH_MEMO, PH_SIG:
                begin
                    // Byte fields: pass the byte on and leave when the field is full.
                    entry.has_payload = 1'b1;
                    entry.byte_offset = 10'(field_count_reg);
                    entry.byte_value  = b;
                    field_count_next  = cnt_inc;
                    unique case (phase_reg)
                        PH_ADDR:
                        begin
                            entry.field_code = irp_pkg::FC_ADDRESS;
                            if (cnt_ext >= {1'b0, addr_size_reg})
                                phase_next = PH_ID;
                        end
                        PH_ID:
                        begin
                            entry.field_code = irp_pkg::FC_MERCHANT;
                            if (cnt_ext >= 17'(ID_BYTES))
                                phase_next = PH_NONCE;
                        end
                        PH_NONCE:
                        begin
                            entry.field_code = irp_pkg::FC_NONCE;
                            if (cnt_ext >= 17'(NONCE_BYTES))
                                phase_next = PH_TIME;
                        end
                        PH_MEMO:
                        begin
                            entry.field_code = irp_pkg::FC_MEMO;
                            if (cnt_ext >= {9'd0, memo_size_reg})
                                phase_next = PH_SIG;
                        end
                        default:
                        begin
                            entry.field_code = irp_pkg::FC_SIG;
                            if (cnt_ext >= 17'(SIG_BYTES))
                                phase_next = PH_DONE;
                        end
                    endcase
                    if (phase_next != phase_reg)
                        field_count_next = '0;
                end
                PH_DONE, PH_ERR:
                begin
                end
                default:
                begin
                end
            endcase

            if (in_data.final_byte)
            begin
                entry.has_status = 1'b1;
                if (error_next != irp_pkg::ST_OK)
                    entry.status = error_next;
                else if (phase_next == PH_DONE)
                    entry.status = irp_pkg::ST_OK;
                else
                    entry.status = irp_pkg::ST_TRUNCATED;
                entry.version   = version_next;
                entry.network   = network_next;
                entry.amount    = amount_next;
                entry.timestamp = time_next;
                entry.expiry    = expiry_next;
                entry.addr_size = addr_size_next;
                entry.memo_size = memo_size_next;

                // The record ends here: start over for the next one.
                phase_next       = PH_VER;
                field_count_next = '0;
                addr_size_next   = '0;
                memo_size_next   = '0;
                version_next     = '0;
                network_next     = '0;
                amount_next      = '0;
                time_next        = '0;
                expiry_next      = '0;
                error_next       = irp_pkg::ST_OK;
            end
        end
    end

    assign push_valid = accept && (entry.has_payload || entry.has_status);
    assign push_data  = entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_VER;
            field_count_reg   <= '0;
            addr_size_reg     <= '0;
            memo_size_reg     <= '0;
            version_reg       <= '0;
            network_reg       <= '0;
            amount_reg        <= '0;
            time_reg          <= '0;
            expiry_reg        <= '0;
            error_reg         <= irp_pkg::ST_OK;
            address_limit_reg <= irp_pkg::ADDRESS_LIMIT_RESET;
            memo_limit_reg    <= irp_pkg::MEMO_LIMIT_RESET;
        end
        else
        begin
            phase_reg       <= phase_next;
            field_count_reg <= field_count_next;
            addr_size_reg   <= addr_size_next;
            memo_size_reg   <= memo_size_next;
            version_reg     <= version_next;
            network_reg     <= network_next;
            amount_reg      <= amount_next;
            time_reg        <= time_next;
            expiry_reg      <= expiry_next;
            error_reg       <= error_next;
            if (cfg_write.valid && cfg_write.index == irp_pkg::CFG_ADDRESS_LIMIT)
                address_limit_reg <= cfg_write.data[9:0];
            if (cfg_write.valid && cfg_write.index == irp_pkg::CFG_MEMO_LIMIT)
                memo_limit_reg <= cfg_write.data[7:0];
        end
    end

    // An error is recorded exactly while the rest of the record is being skipped.
    `IRP_ASSERT(a_error_phase, clk, rst_n, (error_reg != irp_pkg::ST_OK) == (phase_reg == PH_ERR))
    `IRP_ASSERT_IMPL(a_ver_count, clk, rst_n, phase_reg == PH_VER, field_count_reg == '0)

endmodule

>>> rtl/irp_queue.sv
// Short entry queue between the parser front end and the result back end.
// Flip-flop storage, head read combinationally. Uses irp_pkg.
`include "assert_macros.svh"
module irp_queue #(
    parameter int DEPTH = irp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  irp_pkg::entry_t push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output irp_pkg::entry_t pop_data
);

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);

    irp_pkg::entry_t    store_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               push, pop;

    assign push_ready = (count_reg != COUNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = store_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_data;
    end

    `IRP_ASSERT_NEXT(a_fill_grows, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

>>> rtl/irp_back.sv
// Back end of the invoice record parser: takes one entry at a time from the queue
// and presents its payload and status results in order. Uses irp_pkg.
`include "assert_macros.svh"
module irp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  irp_pkg::entry_t  pop_data,
    output logic             out_valid,
    input  logic             out_ready,
    output irp_pkg::result_t out_data
);

    irp_pkg::entry_t entry_reg;
    logic            pend_pay_reg, pend_pay_next;
    logic            pend_stat_reg, pend_stat_next;
    logic            busy, take, last, load;

    assign busy      = pend_pay_reg || pend_stat_reg;
    assign out_valid = busy;
    assign take      = out_valid && out_ready;
    // The payload result goes first; the entry is finished once nothing is left after it.
    assign last      = !(pend_pay_reg && pend_stat_reg);
    assign load      = !busy || (take && last);
    assign pop_ready = load;

    always_comb
    begin
        pend_pay_next  = pend_pay_reg;
        pend_stat_next = pend_stat_reg;
        if (load)
        begin
            pend_pay_next  = pop_valid && pop_data.has_payload;
            pend_stat_next = pop_valid && pop_data.has_status;
        end
        else if (take)
            pend_pay_next = 1'b0;
    end

    always_comb
    begin
        out_data = '0;
        if (pend_pay_reg)
        begin
            out_data.kind        = irp_pkg::KIND_PAYLOAD;
            out_data.field_code  = entry_reg.field_code;
            out_data.byte_offset = entry_reg.byte_offset;
            out_data.byte_value  = entry_reg.byte_value;
        end
        else
        begin
            out_data.kind           = irp_pkg::KIND_STATUS;
            out_data.status         = entry_reg.status;
            out_data.version_out    = entry_reg.version;
            out_data.network_out    = entry_reg.network;
            out_data.amount_out     = entry_reg.amount;
            out_data.time_out       = entry_reg.timestamp;
            out_data.expiry_out     = entry_reg.expiry;
            out_data.address_length = entry_reg.addr_size;
            out_data.memo_length    = entry_reg.memo_size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_pay_reg  <= 1'b0;
            pend_stat_reg <= 1'b0;
        end
        else
        begin
            pend_pay_reg  <= pend_pay_next;
            pend_stat_reg <= pend_stat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && pop_valid)
            entry_reg <= pop_data;
    end

    `IRP_ASSERT_NEXT(a_idle_loads, clk, rst_n, !busy && pop_valid, busy)

endmodule

>>> tb/invoice_record_parser_unit_tb.sv
// Self-checking testbench for invoice_record_parser_unit: drives byte requests and
// limit writes, predicts every payload and status result, and compares them in order.
// Depends on irp_pkg and the invoice_record_parser_unit RTL only.
module invoice_record_parser_unit_tb;

    localparam int CYCLE_LIMIT = 500000;
    localparam logic [irp_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 4'hF;

    typedef enum logic [3:0] {
        P_VERSION, P_NETWORK, P_AMOUNT, P_ADDR_LEN, P_ADDRESS, P_MERCHANT, P_NONCE,
        P_TIME, P_EXPIRY, P_MEMO_LEN, P_MEMO, P_SIGNATURE, P_DONE, P_ERROR
    } parse_phase_t;

    class invoice_scoreboard_t;
        logic [9:0]       address_limit;
        logic [7:0]       memo_limit;
        parse_phase_t     phase;
        logic [15:0]      count;
        logic [15:0]      addr_size_q;
        logic [7:0]       memo_size_q;
        logic [7:0]       version_q;
        logic [7:0]       network_q;
        logic [63:0]      amount_q;
        logic [31:0]      time_q;
        logic [15:0]      expiry_q;
        logic [1:0]       error_q;
        irp_pkg::result_t awaited[$];
        int               mismatches;

        function new();
            address_limit = irp_pkg::ADDRESS_LIMIT_RESET;
            memo_limit    = irp_pkg::MEMO_LIMIT_RESET;
            mismatches    = 0;
            clear_record();
        endfunction

        function void clear_record();
            phase       = P_VERSION;
            count       = '0;
            addr_size_q = '0;
            memo_size_q = '0;
            version_q   = '0;
            network_q   = '0;
            amount_q    = '0;
            time_q      = '0;
            expiry_q    = '0;
            error_q     = irp_pkg::ST_OK;
        endfunction

        function void advance(parse_phase_t next);
            phase = next;
            count = '0;
        endfunction

        function void write_reg(logic [irp_pkg::CFG_INDEX_W-1:0] idx,
                                logic [irp_pkg::CFG_DATA_W-1:0] value);
            if (idx == irp_pkg::CFG_ADDRESS_LIMIT)
                address_limit = value;
            else if (idx == irp_pkg::CFG_MEMO_LIMIT)
                memo_limit = value[7:0];
        endfunction

        function void field_byte(logic [2:0] code, logic [15:0] size, logic [7:0] b,
                                 parse_phase_t next);
            irp_pkg::result_t row;
            row             = '0;
            row.kind        = irp_pkg::KIND_PAYLOAD;
            row.field_code  = code;
            row.byte_offset = count[9:0];
            row.byte_value  = b;
            awaited = {awaited, row};
            count = count + 16'd1;
            if (count >= size)
                advance(next);
        endfunction

        function void note_byte(irp_pkg::item_t it);
            irp_pkg::result_t row;
            logic [7:0]       b;
            logic [15:0]      eff_limit;
            b = it.data_byte;
            eff_limit = (address_limit < irp_pkg::ADDR_CAP_DEF) ? 16'(address_limit)
                                                               : 16'(irp_pkg::ADDR_CAP_DEF);
            unique case (phase)
                P_VERSION:
                begin
                    version_q = b;
                    advance(P_NETWORK);
                end
                P_NETWORK:
                begin
                    network_q = b;
                    advance(P_AMOUNT);
                end
                P_AMOUNT:
                begin
                    amount_q = amount_q | (64'(b) << {count[2:0], 3'b000});
                    count = count + 16'd1;
                    if (count >= 8)
                        advance(P_ADDR_LEN);
                end
                P_ADDR_LEN:
                begin
                    addr_size_q = addr_size_q | (16'(b) << {count[0], 3'b000});
                    count = count + 16'd1;
                    if (count >= 2)
                    begin
                        if (addr_size_q > eff_limit)
                        begin
                            error_q = irp_pkg::ST_ADDR_LONG;
                            advance(P_ERROR);
                        end
                        else if (addr_size_q == 0)
                            advance(P_MERCHANT);
                        else
                            advance(P_ADDRESS);
                    end
                end
                P_ADDRESS:   field_byte(irp_pkg::FC_ADDRESS, addr_size_q, b, P_MERCHANT);
                P_MERCHANT:  field_byte(irp_pkg::FC_MERCHANT, 16'(irp_pkg::ID_BYTES_DEF), b,
                                        P_NONCE);
                P_NONCE:     field_byte(irp_pkg::FC_NONCE, 16'(irp_pkg::NONCE_BYTES_DEF), b,
                                        P_TIME);
                P_TIME:
                begin
                    time_q = time_q | (32'(b) << {count[1:0], 3'b000});
                    count = count + 16'd1;
                    if (count >= 4)
                        advance(P_EXPIRY);
                end
                P_EXPIRY:
                begin
                    expiry_q = expiry_q | (16'(b) << {count[0], 3'b000});
                    count = count + 16'd1;
                    if (count >= 2)
                        advance(P_MEMO_LEN);
                end
                P_MEMO_LEN:
                begin
                    memo_size_q = b;
                    if (memo_size_q > memo_limit)
                    begin
                        error_q = irp_pkg::ST_MEMO_LONG;
                        advance(P_ERROR);
                    end
                    else if (memo_size_q == 0)
                        advance(P_SIGNATURE);
                    else
                        advance(P_MEMO);
                end
                P_MEMO:      field_byte(irp_pkg::FC_MEMO, 16'(memo_size_q), b, P_SIGNATURE);
                P_SIGNATURE: field_byte(irp_pkg::FC_SIG, 16'(irp_pkg::SIG_BYTES_DEF), b,
                                        P_DONE);
                default:     ;
            endcase

            if (it.final_byte)
            begin
                row      = '0;
                row.kind = irp_pkg::KIND_STATUS;
                if (error_q != irp_pkg::ST_OK)
                    row.status = error_q;
                else if (phase == P_DONE)
                    row.status = irp_pkg::ST_OK;
                else
                    row.status = irp_pkg::ST_TRUNCATED;
                row.version_out    = version_q;
                row.network_out    = network_q;
                row.amount_out     = amount_q;
                row.time_out       = time_q;
                row.expiry_out     = expiry_q;
                row.address_length = addr_size_q;
                row.memo_length    = memo_size_q;
                awaited = {awaited, row};
                clear_record();
            end
        endfunction

        function string describe(irp_pkg::result_t r);
            return $sformatf({"kind %0d field %0d offset %0d byte %02h status %0d ",
                              "ver %02h net %02h amount %016h time %08h expiry %04h ",
                              "alen %0d mlen %0d"},
                             r.kind, r.field_code, r.byte_offset, r.byte_value, r.status,
                             r.version_out, r.network_out, r.amount_out, r.time_out,
                             r.expiry_out, r.address_length, r.memo_length);
        endfunction

        function void report(string what, string want, string got);
            mismatches++;
            if (mismatches <= 10)
                $display("%s\n  expected: %s\n  actual:   %s", what, want, got);
        endfunction

        function void check_result(irp_pkg::result_t got);
            irp_pkg::result_t want;
            if (awaited.size() == 0)
                report("unexpected result", "none", describe(got));
            else
            begin
                want = awaited.pop_front();
                if (got.kind !== want.kind || got.field_code !== want.field_code ||
                    got.byte_offset !== want.byte_offset ||
                    got.byte_value !== want.byte_value || got.status !== want.status ||
                    got.version_out !== want.version_out ||
                    got.network_out !== want.network_out ||
                    got.amount_out !== want.amount_out || got.time_out !== want.time_out ||
                    got.expiry_out !== want.expiry_out ||
                    got.address_length !== want.address_length ||
                    got.memo_length !== want.memo_length)
                    report("wrong result", describe(want), describe(got));
            end
        endfunction

        function void check_leftovers();
            while (awaited.size() != 0)
                report("missing result", describe(awaited.pop_front()), "none");
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    irp_pkg::item_t                  in_data = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    irp_pkg::result_t                out_data;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [irp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [irp_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    invoice_scoreboard_t sb = new();
    irp_pkg::item_t      record_bytes[$];
    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    int                  hold_left = 0;
    int                  cycle_count = 0;

    invoice_record_parser_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // Result side: check what was taken at this edge, then pick ready for the next one.
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_result(out_data);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [7:0] fill_byte(int fill);
        logic [7:0] v;
        v = (fill < 0) ? 8'($urandom) : 8'(fill);
        return v;
    endfunction

    // Lays out one record; keep > 0 cuts it to that many bytes, the last one final.
    function automatic void build_record(input int alen, input int mlen, input int keep,
                                         input int tail, input int fill);
        irp_pkg::item_t it;
        int             n;
        int             memo_size_pos;
        memo_size_pos = 12 + alen + irp_pkg::ID_BYTES_DEF + irp_pkg::NONCE_BYTES_DEF + 6;
        n = memo_size_pos + 1 + mlen + irp_pkg::SIG_BYTES_DEF + tail;
        if (keep > 0 && keep < n)
            n = keep;
        record_bytes = {};
        for (int i = 0; i < n; i++)
        begin
            it.data_byte = fill_byte(fill);
            if (i == 10)
                it.data_byte = alen[7:0];
            else if (i == 11)
                it.data_byte = alen[15:8];
            else if (i == memo_size_pos)
                it.data_byte = mlen[7:0];
            it.final_byte = (i == n - 1);
            record_bytes = {record_bytes, it};
        end
    endfunction

    task automatic send_byte(input irp_pkg::item_t it);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        sb.note_byte(it);
    endtask

    task automatic send_record();
        foreach (record_bytes[i])
            send_byte(record_bytes[i]);
    endtask

    task automatic wait_drained();
        do @(posedge clk); while (sb.awaited.size() != 0);
    endtask

    task automatic cfg_write(input logic [irp_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [irp_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, value);
    endtask

    // Limits change only with the block empty; a byte with no result may still be in flight.
    task automatic set_limits(input logic [9:0] addr_val, input logic [9:0] memo_val,
                              input bit touch_unused);
        wait_drained();
        repeat (8) @(posedge clk);
        cfg_write(irp_pkg::CFG_ADDRESS_LIMIT, addr_val);
        cfg_write(irp_pkg::CFG_MEMO_LIMIT, memo_val);
        if (touch_unused)
            cfg_write(CFG_UNUSED_INDEX, 10'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic random_record(output int counted);
        int             alen;
        int             mlen;
        int             keep;
        int             tail;
        int             lim;
        int             mlim;
        int             head;
        int             r;
        irp_pkg::item_t it;
        lim  = int'(sb.address_limit);
        mlim = int'(sb.memo_limit);
        keep = -1;
        tail = 0;
        if ($urandom_range(99) < 8)
        begin
            // Noise: random bytes with scattered final flags.
            record_bytes = {};
            r = $urandom_range(1, 30);
            for (int i = 0; i < r; i++)
            begin
                it.data_byte  = 8'($urandom);
                it.final_byte = (i == r - 1) || ($urandom_range(9) == 0);
                record_bytes = {record_bytes, it};
            end
        end
        else
        begin
            r = $urandom_range(99);
            if (r < 50)      alen = $urandom_range(0, (lim < 12) ? lim : 12);
            else if (r < 60) alen = 0;
            else if (r < 70) alen = (lim <= 160) ? lim : $urandom_range(1, 12);
            else if (r < 82) alen = lim + 1;
            else if (r < 92) alen = $urandom_range(0, 65535);
            else             alen = $urandom_range(0, 40);
            r = $urandom_range(99);
            if (r < 55)      mlen = $urandom_range(0, (mlim < 12) ? mlim : 12);
            else if (r < 65) mlen = 0;
            else if (r < 75) mlen = (mlim <= 80) ? mlim : $urandom_range(0, 12);
            else if (r < 88) mlen = (mlim < 255) ? mlim + 1 : $urandom_range(0, 12);
            else             mlen = $urandom_range(0, 60);
            head = 12 + alen + irp_pkg::ID_BYTES_DEF + irp_pkg::NONCE_BYTES_DEF + 7;
            if (alen > lim)
                keep = 12 + $urandom_range(0, 20);
            else if (mlen > mlim)
                keep = head + $urandom_range(0, 10);
            else
            begin
                r = $urandom_range(99);
                if (r < 20)
                    keep = $urandom_range(1, head + mlen + irp_pkg::SIG_BYTES_DEF);
                else if (r < 35)
                    tail = $urandom_range(1, 6);
            end
            build_record(alen, mlen, keep, tail, -1);
        end
        send_record();
        counted = record_bytes.size() - tail;
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int target,
                             input bit pause_mid);
        int sent;
        int got;
        bit paused;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent   = 0;
        paused = 1'b0;
        while (sent < target)
        begin
            random_record(got);
            sent += got;
            if (pause_mid && !paused && sent >= target / 2)
            begin
                paused = 1'b1;
                in_valid <= 1'b0;
                wait_drained();
            end
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed records under the reset limits (address 128, memo 255).
        build_record(0, 0, 1, 0, -1);            send_record();
        build_record(5, 3, -1, 0, -1);           send_record();
        build_record(0, 0, -1, 0, 8'hFF);        send_record();
        build_record(0, 0, -1, 0, 8'h00);        send_record();
        build_record(128, 0, -1, 0, -1);         send_record();
        build_record(129, 2, 20, 0, -1);         send_record();
        build_record(16'hFFFF, 0, 12, 0, -1);    send_record();
        build_record(3, 1, 5, 0, -1);            send_record();
        build_record(3, 1, 11, 0, -1);           send_record();
        build_record(3, 1, 53, 0, -1);           send_record();
        build_record(3, 1, 56, 0, -1);           send_record();
        build_record(3, 1, 57, 0, -1);           send_record();
        build_record(2, 4, -1, 5, -1);           send_record();
        build_record(1, 2, 120, 0, -1);          send_record();
        in_valid <= 1'b0;

        // Back-pressure burst: the receiver holds off while requests keep coming.
        set_limits(10'd40, 10'h31E, 1'b1);
        hold_left = 300;
        run_phase(0, 0, 120, 1'b0);

        set_limits(10'd0, 10'd0, 1'b0);
        run_phase(61, 0, 120, 1'b0);

        set_limits(10'd1023, 10'd255, 1'b1);
        run_phase(0, 61, 120, 1'b0);

        set_limits(10'($urandom_range(1, 60)), {2'($urandom), 8'($urandom_range(1, 40))},
                   1'b0);
        run_phase(23, 23, 120, 1'b1);

        wait_drained();
        repeat (20) @(posedge clk);
        sb.check_leftovers();
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
